// File: sv/etofm_pkg.sv
// etofm_pkg: shared widths, field types and status codes for the
// Earth-fixed to orbit frame matrix block. No dependencies.
package etofm_pkg;

  localparam int POS_W = 36;
  localparam int VEL_W = 26;
  localparam int OUT_W = 32;
  localparam int ST_W  = 2;

  // Unit-vector datapath: normalised magnitude has its leading one here
  localparam int NORM_MSB = 30;
  localparam int NORM_W   = 31;
  localparam int SQ_W     = 62;
  localparam int SUM_W    = 64;
  localparam int ROOT_W   = 32;

  localparam logic [ST_W-1:0] ST_OK         = 2'd0;
  localparam logic [ST_W-1:0] ST_ZERO_POS   = 2'd1;
  localparam logic [ST_W-1:0] ST_ZERO_CROSS = 2'd2;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [VEL_W-1:0] vel_t;
  typedef logic signed [OUT_W-1:0] elem_t;
  typedef logic [ST_W-1:0]         status_t;

endpackage

// File: sv/etofm_in_if.sv
// etofm_in_if: input channel, one position/velocity item per handshake.
// Depends on etofm_pkg.
interface etofm_in_if;
  logic              valid;
  logic              ready;
  etofm_pkg::pos_t   pos_x;
  etofm_pkg::pos_t   pos_y;
  etofm_pkg::pos_t   pos_z;
  etofm_pkg::vel_t   vel_x;
  etofm_pkg::vel_t   vel_y;
  etofm_pkg::vel_t   vel_z;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

// File: sv/etofm_out_if.sv
// etofm_out_if: result channel, one rotation matrix and status per item.
// Depends on etofm_pkg.
interface etofm_out_if;
  logic               valid;
  logic               ready;
  etofm_pkg::elem_t   m00, m01, m02;
  etofm_pkg::elem_t   m10, m11, m12;
  etofm_pkg::elem_t   m20, m21, m22;
  etofm_pkg::status_t status;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, status,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, status,
                  output ready);
endinterface

// File: sv/etofm_unit.sv
// etofm_unit: pipelined unit-vector unit (normalise, sum of squares,
// bit-serial square root, one-bit-per-stage division). Depends on etofm_pkg.
module etofm_unit #(
  parameter int F  = 30,
  parameter int CW = 37,
  parameter int SW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] comp [3],
  input  logic [SW-1:0]        side_in,
  output logic                 out_valid,
  output logic signed [F+1:0]  u [3],
  output logic                 zero,
  output logic [SW-1:0]        side_out
);

  localparam int PW  = $clog2(CW);
  localparam int NRW = etofm_pkg::NORM_W;
  localparam int RTW = etofm_pkg::ROOT_W;
  localparam int SMW = etofm_pkg::SUM_W;
  localparam int RW  = RTW + 3;
  localparam int NW  = NRW + F + 1;
  localparam int QW  = F + 1;
  localparam int DRW = RTW + 1;
  localparam int SQS = RTW;
  localparam int DVS = F + 1;

  // stage 1: magnitudes
  logic              v1;
  logic [CW-1:0]     a1 [3];
  logic [2:0]        neg1;
  logic [SW-1:0]     side1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= comp[i][CW-1];
        a1[i]   <= comp[i][CW-1] ? $unsigned(-comp[i]) : $unsigned(comp[i]);
      end
      side1 <= side_in;
    end
  end

  // stage 2: leading one of the largest magnitude
  logic [CW-1:0] or_v;
  logic [PW-1:0] lead;
  logic          v2, zero2;
  logic [PW-1:0] p2;
  logic [CW-1:0] a2 [3];
  logic [2:0]    neg2;
  logic [SW-1:0] side2;

  assign or_v = a1[0] | a1[1] | a1[2];

  always_comb begin
    lead = '0;
    for (int i = 0; i < CW; i++) begin
      if (or_v[i]) lead = PW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2    <= lead;
      zero2 <= ~|or_v;
      a2    <= a1;
      neg2  <= neg1;
      side2 <= side1;
    end
  end

  // stage 3: common shift so the largest lands in [2^30, 2^31)
  logic [CW-1:0]  sh [3];
  logic           v3, zero3;
  logic [NRW-1:0] n3 [3];
  logic [2:0]     neg3;
  logic [SW-1:0]  side3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (p2 >= PW'(etofm_pkg::NORM_MSB)) sh[i] = a2[i] >> (p2 - PW'(etofm_pkg::NORM_MSB));
      else sh[i] = a2[i] << (PW'(etofm_pkg::NORM_MSB) - p2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) n3[i] <= sh[i][NRW-1:0];
      zero3 <= zero2;
      neg3  <= neg2;
      side3 <= side2;
    end
  end

  // stage 4: squares
  logic                         v4, zero4;
  logic [etofm_pkg::SQ_W-1:0]   sq4 [3];
  logic [NRW-1:0]               n4 [3];
  logic [2:0]                   neg4;
  logic [SW-1:0]                side4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++)
        sq4[i] <= etofm_pkg::SQ_W'(n3[i]) * etofm_pkg::SQ_W'(n3[i]);
      n4    <= n3;
      zero4 <= zero3;
      neg4  <= neg3;
      side4 <= side3;
    end
  end

  // stage 5 feeds the square-root chain (stage index 0)
  logic [SMW-1:0] sx    [0:SQS];
  logic [RW-1:0]  srem  [0:SQS];
  logic [RTW-1:0] sroot [0:SQS];
  logic [NRW-1:0] sn    [0:SQS][3];
  logic [2:0]     sneg  [0:SQS];
  logic           szero [0:SQS];
  logic [SW-1:0]  sside [0:SQS];
  logic           sv    [0:SQS];

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else if (adv) sv[0] <= v4;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx[0]    <= SMW'(sq4[0]) + SMW'(sq4[1]) + SMW'(sq4[2]);
      srem[0]  <= '0;
      sroot[0] <= '0;
      sn[0]    <= n4;
      sneg[0]  <= neg4;
      szero[0] <= zero4;
      sside[0] <= side4;
    end
  end

  // square root: one result bit per stage
  for (genvar k = 0; k < SQS; k++) begin : g_sqrt
    logic [RW-1:0] t, trial;
    logic          take;

    assign t     = {srem[k][RW-3:0], sx[k][SMW-1:SMW-2]};
    assign trial = RW'({sroot[k], 2'b01});
    assign take  = t >= trial;

    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else if (adv) sv[k+1] <= sv[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sx[k+1]    <= sx[k] << 2;
        srem[k+1]  <= take ? t - trial : t;
        sroot[k+1] <= {sroot[k][RTW-2:0], take};
        sn[k+1]    <= sn[k];
        sneg[k+1]  <= sneg[k];
        szero[k+1] <= szero[k];
        sside[k+1] <= sside[k];
      end
    end
  end

  // division set-up: dividend a*2^F + L/2, initial partial remainder
  logic [NW-1:0]  nv [3];
  logic [NW-1:0]  dn    [0:DVS][3];
  logic [DRW-1:0] drem  [0:DVS][3];
  logic [QW-1:0]  dq    [0:DVS][3];
  logic [RTW-1:0] dl    [0:DVS];
  logic [2:0]     dneg  [0:DVS];
  logic           dzero [0:DVS];
  logic [SW-1:0]  dside [0:DVS];
  logic           dv    [0:DVS];

  always_comb begin
    for (int i = 0; i < 3; i++)
      nv[i] = (NW'(sn[SQS][i]) << F) + NW'(sroot[SQS] >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (adv) dv[0] <= sv[SQS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dn[0][i]   <= nv[i];
        drem[0][i] <= DRW'(nv[i] >> (F + 1));
        dq[0][i]   <= '0;
      end
      dl[0]    <= sroot[SQS];
      dneg[0]  <= sneg[SQS];
      dzero[0] <= szero[SQS];
      dside[0] <= sside[SQS];
    end
  end

  // restoring division: one quotient bit per stage, three lanes
  for (genvar j = 0; j < DVS; j++) begin : g_div
    logic [DRW-1:0] t [3];
    logic [2:0]     take;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]    = {drem[j][i][DRW-2:0], dn[j][i][F-j]};
        take[i] = t[i] >= {1'b0, dl[j]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv[j+1] <= 1'b0;
      else if (adv) dv[j+1] <= dv[j];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          dn[j+1][i]   <= dn[j][i];
          drem[j+1][i] <= take[i] ? t[i] - {1'b0, dl[j]} : t[i];
          dq[j+1][i]   <= {dq[j][i][QW-2:0], take[i]};
        end
        dl[j+1]    <= dl[j];
        dneg[j+1]  <= dneg[j];
        dzero[j+1] <= dzero[j];
        dside[j+1] <= dside[j];
      end
    end
  end

  // sign restore
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= dv[DVS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++)
        u[i] <= dneg[DVS][i] ? -$signed({1'b0, dq[DVS][i]}) : $signed({1'b0, dq[DVS][i]});
      zero     <= dzero[DVS];
      side_out <= dside[DVS];
    end
  end

endmodule

// File: sv/etofm_cross.sv
// etofm_cross: two-stage cross product of the radial unit vector with the
// velocity, exact integer products. Depends on etofm_pkg.
module etofm_cross #(
  parameter int F  = 30,
  parameter int SW = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic signed [F+1:0]                 wz [3],
  input  logic signed [etofm_pkg::VEL_W-1:0]  vel [3],
  input  logic [SW-1:0]                       side_in,
  output logic                                out_valid,
  output logic signed [F+etofm_pkg::VEL_W+2:0] cr [3],
  output logic [SW-1:0]                       side_out
);

  localparam int PRW = F + 2 + etofm_pkg::VEL_W;
  localparam int CRW = PRW + 1;

  logic                  v1;
  logic signed [PRW-1:0] p [6];
  logic [SW-1:0]         side1;

  // products: cr0 = z1*v2 - z2*v1, cr1 = z2*v0 - z0*v2, cr2 = z0*v1 - z1*v0
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p[0]  <= PRW'(wz[1]) * PRW'(vel[2]);
      p[1]  <= PRW'(wz[2]) * PRW'(vel[1]);
      p[2]  <= PRW'(wz[2]) * PRW'(vel[0]);
      p[3]  <= PRW'(wz[0]) * PRW'(vel[2]);
      p[4]  <= PRW'(wz[0]) * PRW'(vel[1]);
      p[5]  <= PRW'(wz[1]) * PRW'(vel[0]);
      side1 <= side_in;
    end
  end

  // differences
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cr[0]    <= CRW'(p[0]) - CRW'(p[1]);
      cr[1]    <= CRW'(p[2]) - CRW'(p[3]);
      cr[2]    <= CRW'(p[4]) - CRW'(p[5]);
      side_out <= side1;
    end
  end

endmodule

// File: sv/etofm_trans.sv
// etofm_trans: transverse row wy x wz with round-to-nearest (ties away)
// and saturation to +/-2^F, four stages. Depends on etofm_pkg.
module etofm_trans #(
  parameter int F  = 30,
  parameter int SW = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic signed [F+1:0] wy [3],
  input  logic signed [F+1:0] wz [3],
  input  logic [SW-1:0]       side_in,
  output logic                out_valid,
  output logic signed [F+1:0] wx [3],
  output logic [SW-1:0]       side_out
);

  localparam int PRW = 2 * (F + 2);
  localparam int DW  = PRW + 1;
  localparam int QRW = DW - F;

  // products
  logic                  v1;
  logic signed [PRW-1:0] p [6];
  logic [SW-1:0]         side1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p[0]  <= PRW'(wy[1]) * PRW'(wz[2]);
      p[1]  <= PRW'(wy[2]) * PRW'(wz[1]);
      p[2]  <= PRW'(wy[2]) * PRW'(wz[0]);
      p[3]  <= PRW'(wy[0]) * PRW'(wz[2]);
      p[4]  <= PRW'(wy[0]) * PRW'(wz[1]);
      p[5]  <= PRW'(wy[1]) * PRW'(wz[0]);
      side1 <= side_in;
    end
  end

  // differences
  logic                 v2;
  logic signed [DW-1:0] d [3];
  logic [SW-1:0]        side2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d[0]  <= DW'(p[0]) - DW'(p[1]);
      d[1]  <= DW'(p[2]) - DW'(p[3]);
      d[2]  <= DW'(p[4]) - DW'(p[5]);
      side2 <= side1;
    end
  end

  // magnitude and sign
  logic          v3;
  logic [DW-1:0] m3 [3];
  logic [2:0]    neg3;
  logic [SW-1:0] side3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        neg3[i] <= d[i][DW-1];
        m3[i]   <= d[i][DW-1] ? $unsigned(-d[i]) : $unsigned(d[i]);
      end
      side3 <= side2;
    end
  end

  // round, saturate, sign
  logic [DW-1:0]  rs [3];
  logic [QRW-1:0] q  [3];
  logic [F:0]     qs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rs[i] = m3[i] + (DW'(1) << (F - 1));
      q[i]  = QRW'(rs[i] >> F);
      qs[i] = (q[i] > QRW'(1) << F) ? (F+1)'(1) << F : q[i][F:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= v3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++)
        wx[i] <= neg3[i] ? -$signed({1'b0, qs[i]}) : $signed({1'b0, qs[i]});
      side_out <= side3;
    end
  end

endmodule

// File: sv/earth_to_orbit_frame_matrix_core.sv
// Earth-fixed to orbit frame rotation matrix, fully pipelined.
// Stages: two unit-vector units of F+40 stages each (32-stage square root,
// F+1-stage divider), cross product 2, transverse row 4, output register 1.
// Throughput one item per cycle.
// The whole pipeline holds while a result waits at the output.
// Synchronous reset clears all valid bits; data registers are not reset.
module earth_to_orbit_frame_matrix_core #(
  parameter int OUTPUT_FRACTION_BITS = 30
) (
  input  logic        clk,
  input  logic        rst,
  etofm_in_if.sink    ingress,
  etofm_out_if.source egress
);

  localparam int F   = OUTPUT_FRACTION_BITS;
  localparam int PW1 = etofm_pkg::POS_W + 1;
  localparam int VW  = etofm_pkg::VEL_W;
  localparam int CRW = F + VW + 3;
  localparam int UW  = F + 2;
  localparam int S1W = 3 * VW;
  localparam int S2W = 1 + 3 * UW;
  localparam int S3W = etofm_pkg::ST_W + 6 * UW;

  logic adv;

  assign adv           = ~egress.valid | egress.ready;
  assign ingress.ready = adv;

  // radial unit vector from the negated position
  logic signed [PW1-1:0] np [3];
  logic signed [VW-1:0]  vin [3];

  assign np[0]  = -PW1'(ingress.pos_x);
  assign np[1]  = -PW1'(ingress.pos_y);
  assign np[2]  = -PW1'(ingress.pos_z);
  assign vin[0] = ingress.vel_x;
  assign vin[1] = ingress.vel_y;
  assign vin[2] = ingress.vel_z;

  logic                 u1_valid, u1_zero;
  logic signed [UW-1:0] wz1 [3];
  logic [S1W-1:0]       u1_side;

  etofm_unit #(.F(F), .CW(PW1), .SW(S1W)) u_radial (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(ingress.valid),
    .comp(np), .side_in({vin[0], vin[1], vin[2]}),
    .out_valid(u1_valid), .u(wz1), .zero(u1_zero), .side_out(u1_side)
  );

  // cross product with the velocity
  logic signed [VW-1:0]  vel1 [3];
  logic                  cr_valid;
  logic signed [CRW-1:0] cr [3];
  logic [S2W-1:0]        cr_side;

  assign vel1[0] = $signed(u1_side[3*VW-1:2*VW]);
  assign vel1[1] = $signed(u1_side[2*VW-1:VW]);
  assign vel1[2] = $signed(u1_side[VW-1:0]);

  etofm_cross #(.F(F), .SW(S2W)) u_cross (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(u1_valid),
    .wz(wz1), .vel(vel1), .side_in({u1_zero, wz1[0], wz1[1], wz1[2]}),
    .out_valid(cr_valid), .cr(cr), .side_out(cr_side)
  );

  // orbit normal unit vector
  logic                 u2_valid, u2_zero;
  logic signed [UW-1:0] wy2 [3];
  logic [S2W-1:0]       u2_side;

  etofm_unit #(.F(F), .CW(CRW), .SW(S2W)) u_normal (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(cr_valid),
    .comp(cr), .side_in(cr_side),
    .out_valid(u2_valid), .u(wy2), .zero(u2_zero), .side_out(u2_side)
  );

  // status, and transverse row
  logic signed [UW-1:0]    wz2 [3];
  etofm_pkg::status_t      st2;
  logic                    tr_valid;
  logic signed [UW-1:0]    wx [3];
  logic [S3W-1:0]          tr_side;

  assign wz2[0] = $signed(u2_side[3*UW-1:2*UW]);
  assign wz2[1] = $signed(u2_side[2*UW-1:UW]);
  assign wz2[2] = $signed(u2_side[UW-1:0]);

  always_comb begin
    priority if (u2_side[S2W-1]) st2 = etofm_pkg::ST_ZERO_POS;
    else if (u2_zero)            st2 = etofm_pkg::ST_ZERO_CROSS;
    else                         st2 = etofm_pkg::ST_OK;
  end

  etofm_trans #(.F(F), .SW(S3W)) u_trans (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(u2_valid),
    .wy(wy2), .wz(wz2),
    .side_in({st2, wy2[0], wy2[1], wy2[2], wz2[0], wz2[1], wz2[2]}),
    .out_valid(tr_valid), .wx(wx), .side_out(tr_side)
  );

  // output register: zero matrix on any error
  etofm_pkg::status_t   st3;
  logic signed [UW-1:0] wy3 [3];
  logic signed [UW-1:0] wz3 [3];
  logic                 ok3;

  assign st3    = tr_side[S3W-1:S3W-etofm_pkg::ST_W];
  assign wy3[0] = $signed(tr_side[6*UW-1:5*UW]);
  assign wy3[1] = $signed(tr_side[5*UW-1:4*UW]);
  assign wy3[2] = $signed(tr_side[4*UW-1:3*UW]);
  assign wz3[0] = $signed(tr_side[3*UW-1:2*UW]);
  assign wz3[1] = $signed(tr_side[2*UW-1:UW]);
  assign wz3[2] = $signed(tr_side[UW-1:0]);
  assign ok3    = st3 == etofm_pkg::ST_OK;

  always_ff @(posedge clk) begin
    if (rst) egress.valid <= 1'b0;
    else if (adv) egress.valid <= tr_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      egress.m00    <= ok3 ? etofm_pkg::OUT_W'(wx[0])  : '0;
      egress.m01    <= ok3 ? etofm_pkg::OUT_W'(wx[1])  : '0;
      egress.m02    <= ok3 ? etofm_pkg::OUT_W'(wx[2])  : '0;
      egress.m10    <= ok3 ? etofm_pkg::OUT_W'(wy3[0]) : '0;
      egress.m11    <= ok3 ? etofm_pkg::OUT_W'(wy3[1]) : '0;
      egress.m12    <= ok3 ? etofm_pkg::OUT_W'(wy3[2]) : '0;
      egress.m20    <= ok3 ? etofm_pkg::OUT_W'(wz3[0]) : '0;
      egress.m21    <= ok3 ? etofm_pkg::OUT_W'(wz3[1]) : '0;
      egress.m22    <= ok3 ? etofm_pkg::OUT_W'(wz3[2]) : '0;
      egress.status <= st3;
    end
  end

endmodule
